@@ rtl/multichannel_peak_meter_macros.svh @@
// Assertion macros shared by the peak meter checker
`ifndef MULTICHANNEL_PEAK_METER_MACROS_SVH
`define MULTICHANNEL_PEAK_METER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PKM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PKM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pkm_pkg.sv @@
// Types and constants of the multichannel peak meter
package pkm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PEAK_BITS   = SAMPLE_BITS - 1;
    localparam int CHAN_BITS   = 3;
    localparam int CNT_BITS    = 4;
    localparam int KIND_BITS   = 3;

    localparam logic [PEAK_BITS-1:0] PEAK_FLOOR = 23'd84;
    localparam logic [PEAK_BITS-1:0] PEAK_MAX   = 23'h7FFFFF;
    localparam logic [CNT_BITS-1:0]  READ_LIMIT = 4'd8;
    localparam logic [CNT_BITS-1:0]  ACTIVE_RESET = 4'd8;

    localparam logic [KIND_BITS-1:0] KIND_SAMPLE   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_READ_CH  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ_OVR = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_READ_ALL = 3'd4;

    typedef struct packed {
        logic [KIND_BITS-1:0]          kind;
        logic [CHAN_BITS-1:0]          channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clear_after_read;
    } pkm_in_t;

    typedef struct packed {
        logic [PEAK_BITS-1:0] peak_value;
        logic [CHAN_BITS-1:0] peak_channel;
        logic                 last;
        logic                 bad_channel;
    } pkm_out_t;

    // sequencer -> datapath controls
    typedef struct packed {
        logic                 upd_ch;
        logic                 upd_all;
        logic                 walk;
        logic                 walk_last;
        logic [CHAN_BITS-1:0] walk_idx;
    } pkm_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_UPD_CH  = 4'b0010,
        ST_UPD_ALL = 4'b0100,
        ST_WALK    = 4'b1000
    } pkm_state_t;

endpackage

@@ rtl/multichannel_peak_meter.sv @@
// Multichannel peak meter: peak stores, result register and unit hookup
//
// Commands enter on cmd when start is high and busy is low. Samples update
// the peak of their channel and the overall peak; reads return words on
// result, each shown for exactly one cycle with result_valid high.
// For a sample, the accept cycle registers the magnitude, then the single
// compare unit checks the channel peak and then the overall peak.
// Single-channel and overall reads and clear-all are done in the accept cycle;
// read-all then walks the n active channels, one word per cycle, last set on
// the final word. Result words are registered and appear in the cycle after the
// cycle that produces them. Samples on channels at or above the active count
// are dropped; a single-channel read there returns a word with bad_channel.
// active_channels is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while idle (not enforced). Reset sets every channel peak to the floor
// value 84, the overall peak and its channel to zero, and active_channels to 8.
// The receiver cannot stall: every word must be taken in the cycle it is shown.
module multichannel_peak_meter #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pkm_pkg::pkm_in_t             cmd,
    input  logic                         cfg_wr_en,
    input  logic [pkm_pkg::CNT_BITS-1:0] cfg_wr_data,
    output pkm_pkg::pkm_out_t            result,
    output logic                         result_valid
);

    localparam int DEPTH = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [pkm_pkg::CNT_BITS-1:0] DEPTH_CNT = 4'(DEPTH);

    logic [pkm_pkg::PEAK_BITS-1:0] peak_reg [DEPTH];
    logic [pkm_pkg::PEAK_BITS-1:0] peak_next [DEPTH];
    logic [pkm_pkg::PEAK_BITS-1:0] ovr_reg, ovr_next;
    logic [pkm_pkg::CHAN_BITS-1:0] ovr_ch_reg, ovr_ch_next;
    logic [pkm_pkg::CNT_BITS-1:0]  active_reg;
    logic [pkm_pkg::CHAN_BITS-1:0] ch_reg, ch_next;
    logic                          clr_reg, clr_next;
    pkm_pkg::pkm_out_t             out_reg, out_next;
    logic                          valid_reg, valid_next;

    logic [pkm_pkg::CNT_BITS-1:0]  n_cnt;
    logic                          accept;
    logic                          chan_ok;
    logic [IDX_W-1:0]              cmd_idx, ch_idx, walk_idx;
    pkm_pkg::pkm_ctl_t             ctl;
    logic [pkm_pkg::PEAK_BITS-1:0] operand;
    logic [pkm_pkg::PEAK_BITS-1:0] mag;
    logic                          gt;

    assign n_cnt    = (active_reg > DEPTH_CNT) ? DEPTH_CNT : active_reg;
    assign accept   = start && !busy;
    assign chan_ok  = {1'b0, cmd.channel} < n_cnt;
    assign cmd_idx  = cmd.channel[IDX_W-1:0];
    assign ch_idx   = ch_reg[IDX_W-1:0];
    assign walk_idx = ctl.walk_idx[IDX_W-1:0];
    assign operand  = ctl.upd_all ? ovr_reg : peak_reg[ch_idx];

    pkm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (cmd.kind),
        .chan_ok (chan_ok),
        .n_cnt   (n_cnt),
        .busy    (busy),
        .ctl     (ctl)
    );

    pkm_mag_cmp u_mag_cmp (
        .clk     (clk),
        .load    (accept),
        .sample  (cmd.sample),
        .operand (operand),
        .mag     (mag),
        .gt      (gt)
    );

    always_comb
    begin
        peak_next   = peak_reg;
        ovr_next    = ovr_reg;
        ovr_ch_next = ovr_ch_reg;
        ch_next     = ch_reg;
        clr_next    = clr_reg;
        out_next    = out_reg;
        valid_next  = 1'b0;

        if (accept)
        begin
            ch_next  = cmd.channel;
            clr_next = cmd.clear_after_read;
            unique case (cmd.kind)
                pkm_pkg::KIND_READ_CH:
                begin
                    valid_next           = 1'b1;
                    out_next.peak_channel = cmd.channel;
                    out_next.last        = 1'b1;
                    if (chan_ok)
                    begin
                        out_next.peak_value  = peak_reg[cmd_idx];
                        out_next.bad_channel = 1'b0;
                        if (cmd.clear_after_read)
                        begin
                            peak_next[cmd_idx] = '0;
                        end
                    end
                    else
                    begin
                        out_next.peak_value  = '0;
                        out_next.bad_channel = 1'b1;
                    end
                end
                pkm_pkg::KIND_READ_OVR:
                begin
                    valid_next            = 1'b1;
                    out_next.peak_value   = ovr_reg;
                    out_next.peak_channel = ovr_ch_reg;
                    out_next.last         = 1'b1;
                    out_next.bad_channel  = 1'b0;
                    if (cmd.clear_after_read)
                    begin
                        ovr_next    = '0;
                        ovr_ch_next = '0;
                    end
                end
                pkm_pkg::KIND_CLEAR:
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        peak_next[i] = pkm_pkg::PEAK_FLOOR;
                    end
                    ovr_next    = '0;
                    ovr_ch_next = '0;
                end
                pkm_pkg::KIND_READ_ALL:
                begin
                    // no active channel: single error word
                    if (n_cnt == '0)
                    begin
                        valid_next            = 1'b1;
                        out_next.peak_value   = '0;
                        out_next.peak_channel = '0;
                        out_next.last         = 1'b1;
                        out_next.bad_channel  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.upd_ch && gt)
        begin
            peak_next[ch_idx] = mag;
        end

        if (ctl.upd_all && gt)
        begin
            ovr_next    = mag;
            ovr_ch_next = ch_reg;
        end

        if (ctl.walk)
        begin
            valid_next            = 1'b1;
            out_next.peak_value   = peak_reg[walk_idx];
            out_next.peak_channel = ctl.walk_idx;
            out_next.last         = ctl.walk_last;
            out_next.bad_channel  = 1'b0;
            if (clr_reg)
            begin
                peak_next[walk_idx] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                peak_reg[i] <= pkm_pkg::PEAK_FLOOR;
            end
            ovr_reg    <= '0;
            ovr_ch_reg <= '0;
            active_reg <= pkm_pkg::ACTIVE_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            peak_reg   <= peak_next;
            ovr_reg    <= ovr_next;
            ovr_ch_reg <= ovr_ch_next;
            valid_reg  <= valid_next;
            if (cfg_wr_en)
            begin
                active_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        clr_reg <= clr_next;
        out_reg <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = valid_reg;

endmodule

@@ rtl/pkm_mag_cmp.sv @@
// Shared magnitude register and compare unit
module pkm_mag_cmp (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic signed [pkm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [pkm_pkg::PEAK_BITS-1:0]        operand,
    output logic [pkm_pkg::PEAK_BITS-1:0]        mag,
    output logic                                 gt
);

    logic [pkm_pkg::PEAK_BITS-1:0]   mag_reg;
    logic [pkm_pkg::PEAK_BITS-1:0]   mag_next;
    logic [pkm_pkg::SAMPLE_BITS-1:0] neg;

    always_comb
    begin
        neg = -sample;
        if (!sample[pkm_pkg::SAMPLE_BITS-1])
        begin
            mag_next = sample[pkm_pkg::PEAK_BITS-1:0];
        end
        else if (neg[pkm_pkg::SAMPLE_BITS-1])
        begin
            // most negative code saturates
            mag_next = pkm_pkg::PEAK_MAX;
        end
        else
        begin
            mag_next = neg[pkm_pkg::PEAK_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;
    assign gt  = mag_reg > operand;

endmodule

@@ rtl/pkm_seq.sv @@
// Sequencer: sample update steps and read-all walk
module pkm_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [pkm_pkg::KIND_BITS-1:0] kind,
    input  logic                          chan_ok,
    input  logic [pkm_pkg::CNT_BITS-1:0]  n_cnt,
    output logic                          busy,
    output pkm_pkg::pkm_ctl_t             ctl
);

    pkm_pkg::pkm_state_t state_reg, state_next;
    logic [pkm_pkg::CHAN_BITS-1:0] walk_reg, walk_next;
    logic                          walk_last;

    assign walk_last = ({1'b0, walk_reg} + 4'd1) == n_cnt;

    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        unique case (state_reg)
            pkm_pkg::ST_IDLE:
            begin
                walk_next = '0;
                if (accept && kind == pkm_pkg::KIND_SAMPLE && chan_ok)
                begin
                    state_next = pkm_pkg::ST_UPD_CH;
                end
                else if (accept && kind == pkm_pkg::KIND_READ_ALL && n_cnt != '0)
                begin
                    state_next = pkm_pkg::ST_WALK;
                end
            end
            pkm_pkg::ST_UPD_CH:
            begin
                state_next = pkm_pkg::ST_UPD_ALL;
            end
            pkm_pkg::ST_UPD_ALL:
            begin
                state_next = pkm_pkg::ST_IDLE;
            end
            pkm_pkg::ST_WALK:
            begin
                walk_next = walk_reg + 3'd1;
                if (walk_last)
                begin
                    state_next = pkm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pkm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pkm_pkg::ST_IDLE;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    assign busy          = state_reg != pkm_pkg::ST_IDLE;
    assign ctl.upd_ch    = state_reg == pkm_pkg::ST_UPD_CH;
    assign ctl.upd_all   = state_reg == pkm_pkg::ST_UPD_ALL;
    assign ctl.walk      = state_reg == pkm_pkg::ST_WALK;
    assign ctl.walk_last = walk_last;
    assign ctl.walk_idx  = walk_reg;

endmodule

@@ rtl/pkm_checker.sv @@
// Port-level checker for the peak meter, bound to the top level
`include "multichannel_peak_meter_macros.svh"

module pkm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input pkm_pkg::pkm_in_t             cmd,
    input pkm_pkg::pkm_out_t            result,
    input logic                         result_valid
);

    logic acc;
    assign acc = start && !busy;

    `PKM_ASSERT_NEXT(a_sample_silent, acc && cmd.kind == pkm_pkg::KIND_SAMPLE, !result_valid, "sample produced a word")
    `PKM_ASSERT_NEXT(a_single_read, acc && (cmd.kind == pkm_pkg::KIND_READ_CH || cmd.kind == pkm_pkg::KIND_READ_OVR), result_valid && result.last, "single read gave no last word")
    `PKM_ASSERT_NEXT(a_run_continues, result_valid && !result.last, result_valid, "read-all run broke off")
    `PKM_ASSERT_NOW(a_run_busy, result_valid && !result.last, busy, "not busy inside a read-all run")
    `PKM_ASSERT_NOW(a_bad_zero, result_valid && result.bad_channel, result.peak_value == '0 && result.last, "bad channel word not zero and last")

endmodule

bind multichannel_peak_meter pkm_checker u_pkm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result       (result),
    .result_valid (result_valid)
);

@@ tb/sv/multichannel_peak_meter_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the multichannel peak meter
module multichannel_peak_meter_test;

    localparam int NUM_CH = 8;
    // kinds 5..7 are not decoded and must be dropped
    localparam logic [pkm_pkg::KIND_BITS-1:0]   KIND_SPARE      = 3'd5;
    localparam logic [pkm_pkg::SAMPLE_BITS-1:0] SAMPLE_MOST_NEG = 24'h800000;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         start       = 1'b0;
    logic                         busy;
    pkm_pkg::pkm_in_t             cmd         = '0;
    logic                         cfg_wr_en   = 1'b0;
    logic [pkm_pkg::CNT_BITS-1:0] cfg_wr_data = '0;
    pkm_pkg::pkm_out_t            result;
    logic                         result_valid;

    multichannel_peak_meter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result       (result),
        .result_valid (result_valid)
    );

    // Shadow copy of the meter state
    logic [pkm_pkg::PEAK_BITS-1:0] peak_ch [NUM_CH];
    logic [pkm_pkg::PEAK_BITS-1:0] ovr_peak;
    logic [pkm_pkg::CHAN_BITS-1:0] ovr_chan;
    logic [pkm_pkg::CNT_BITS-1:0]  act_cnt;

    pkm_pkg::pkm_in_t  pending_words [$];
    pkm_pkg::pkm_out_t due_words [$];
    int unsigned n_queued   = 0;
    int unsigned n_taken    = 0;
    int unsigned fail_count = 0;
    bit          word_taken = 1'b0;
    int unsigned gap_left   = 0;
    bit          no_gaps    = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    // Apply one accepted command word to the shadow state, queue its peak words
    function automatic void meter_step(input pkm_pkg::pkm_in_t w);
        logic [pkm_pkg::CNT_BITS-1:0]    n;
        int unsigned                     c;
        logic [pkm_pkg::SAMPLE_BITS-1:0] neg;
        logic [pkm_pkg::PEAK_BITS-1:0]   mag;
        n = (act_cnt > pkm_pkg::READ_LIMIT) ? pkm_pkg::READ_LIMIT : act_cnt;
        case (w.kind)
            pkm_pkg::KIND_SAMPLE:
            begin
                if (w.channel < n)
                begin
                    neg = -w.sample;
                    if (!w.sample[pkm_pkg::SAMPLE_BITS-1])
                        mag = w.sample[pkm_pkg::PEAK_BITS-1:0];
                    else if (w.sample == SAMPLE_MOST_NEG)
                        mag = pkm_pkg::PEAK_MAX;
                    else
                        mag = neg[pkm_pkg::PEAK_BITS-1:0];
                    if (mag > peak_ch[w.channel])
                        peak_ch[w.channel] = mag;
                    if (mag > ovr_peak)
                    begin
                        ovr_peak = mag;
                        ovr_chan = w.channel;
                    end
                end
            end
            pkm_pkg::KIND_READ_CH:
            begin
                if (w.channel >= n)
                    due_words.push_back(pkm_pkg::pkm_out_t'{'0, w.channel, 1'b1, 1'b1});
                else
                begin
                    due_words.push_back(pkm_pkg::pkm_out_t'{peak_ch[w.channel], w.channel,
                                                            1'b1, 1'b0});
                    if (w.clear_after_read)
                        peak_ch[w.channel] = '0;
                end
            end
            pkm_pkg::KIND_READ_OVR:
            begin
                due_words.push_back(pkm_pkg::pkm_out_t'{ovr_peak, ovr_chan, 1'b1, 1'b0});
                if (w.clear_after_read)
                begin
                    ovr_peak = '0;
                    ovr_chan = '0;
                end
            end
            pkm_pkg::KIND_CLEAR:
            begin
                for (c = 0; c < NUM_CH; c++)
                    peak_ch[pkm_pkg::CHAN_BITS'(c)] = pkm_pkg::PEAK_FLOOR;
                ovr_peak = '0;
                ovr_chan = '0;
            end
            pkm_pkg::KIND_READ_ALL:
            begin
                if (n == 0)
                    due_words.push_back(pkm_pkg::pkm_out_t'{'0, '0, 1'b1, 1'b1});
                for (c = 0; c < n; c++)
                begin
                    due_words.push_back(pkm_pkg::pkm_out_t'{peak_ch[pkm_pkg::CHAN_BITS'(c)],
                                                            pkm_pkg::CHAN_BITS'(c),
                                                            (c + 1 == n), 1'b0});
                    if (w.clear_after_read)
                        peak_ch[pkm_pkg::CHAN_BITS'(c)] = '0;
                end
            end
            default:
                ;
        endcase
    endfunction

    task automatic log_fault(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Monitor: check result words, track config writes and accepted commands
    always @(posedge clk)
    begin : word_monitor
        pkm_pkg::pkm_out_t exp_w;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (due_words.size() == 0)
                    log_fault($sformatf("%0t: unexpected peak word value %0h ch %0d last %0b bad %0b",
                                        $time, result.peak_value, result.peak_channel,
                                        result.last, result.bad_channel));
                else
                begin
                    exp_w = due_words.pop_front();
                    if (result.peak_value !== exp_w.peak_value ||
                        result.peak_channel !== exp_w.peak_channel ||
                        result.last !== exp_w.last ||
                        result.bad_channel !== exp_w.bad_channel)
                        log_fault($sformatf({"%0t: peak word mismatch, expected value %0h ch %0d",
                                             " last %0b bad %0b, got value %0h ch %0d",
                                             " last %0b bad %0b"},
                                            $time, exp_w.peak_value, exp_w.peak_channel,
                                            exp_w.last, exp_w.bad_channel,
                                            result.peak_value, result.peak_channel,
                                            result.last, result.bad_channel));
                end
            end
            if (cfg_wr_en)
                act_cnt = cfg_wr_data;
            if (start && !busy)
            begin
                word_taken = 1'b1;
                n_taken++;
                meter_step(cmd);
            end
        end
    end

    // Driver: present queued command words with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !word_taken)
            start <= 1'b1;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (pending_words.size() > 0)
        begin
            cmd   <= pending_words.pop_front();
            start <= 1'b1;
            if ($urandom_range(0, 15) == 0)
                no_gaps = !no_gaps;
            gap_left = no_gaps ? 0 : $urandom_range(0, 4);
        end
        else
            start <= 1'b0;
    end

    task automatic push_word(input logic [pkm_pkg::KIND_BITS-1:0] kind, input int unsigned ch,
                             input logic [pkm_pkg::SAMPLE_BITS-1:0] smp, input bit clr);
        pkm_pkg::pkm_in_t w;
        w.kind             = kind;
        w.channel          = pkm_pkg::CHAN_BITS'(ch);
        w.sample           = smp;
        w.clear_after_read = clr;
        pending_words.push_back(w);
        n_queued++;
    endtask

    // Wait until every command is taken, every word has come and the block is idle
    task automatic drain();
        while (n_taken != n_queued || due_words.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic set_channels(input logic [pkm_pkg::CNT_BITS-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random traffic, mostly samples on active channels mixed with reads, clears and undecoded kinds
    task automatic run_mix(input int unsigned count);
        int unsigned                     done;
        int unsigned                     r;
        int unsigned                     ch;
        logic [pkm_pkg::CNT_BITS-1:0]    n;
        logic [pkm_pkg::SAMPLE_BITS-1:0] smp;
        bit                              clr;
        done = 0;
        while (done < count)
        begin
            n  = (act_cnt > pkm_pkg::READ_LIMIT) ? pkm_pkg::READ_LIMIT : act_cnt;
            ch = (n > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, n - 1)
                                                       : $urandom_range(0, NUM_CH - 1);
            r = $urandom_range(0, 9);
            if (r == 0)
                smp = SAMPLE_MOST_NEG;
            else
            begin
                if (r == 1)
                    smp = pkm_pkg::SAMPLE_BITS'($urandom_range(0, 200));
                else if (r == 2)
                    smp = {1'b0, pkm_pkg::PEAK_MAX};
                else
                    smp = pkm_pkg::SAMPLE_BITS'(($urandom & 32'h7FFFFF) >>
                                                $urandom_range(0, 22));
                if ($urandom_range(0, 1))
                    smp = -smp;
            end
            clr = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                push_word(pkm_pkg::KIND_SAMPLE, ch, smp, clr);
                if (ch < n)
                    done++;
            end
            else if (r < 70)
            begin
                push_word(pkm_pkg::KIND_READ_CH, ch, smp, clr);
                done++;
            end
            else if (r < 80)
            begin
                push_word(pkm_pkg::KIND_READ_OVR, ch, smp, clr);
                done++;
            end
            else if (r < 88)
            begin
                push_word(pkm_pkg::KIND_READ_ALL, ch, smp, clr);
                done++;
            end
            else if (r < 92)
            begin
                push_word(pkm_pkg::KIND_CLEAR, ch, smp, clr);
                done++;
            end
            else
                push_word(pkm_pkg::KIND_BITS'(KIND_SPARE + $urandom_range(0, 2)), ch, smp, clr);
        end
    endtask

    initial
    begin : stimulus
        int unsigned c;
        for (c = 0; c < NUM_CH; c++)
            peak_ch[pkm_pkg::CHAN_BITS'(c)] = pkm_pkg::PEAK_FLOOR;
        ovr_peak = '0;
        ovr_chan = '0;
        act_cnt  = pkm_pkg::ACTIVE_RESET;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Floor values after reset, then magnitude corner cases, clearing reads, clear-all and an undecoded kind
        push_word(pkm_pkg::KIND_READ_ALL, 0, 24'h000000, 1'b0);
        push_word(pkm_pkg::KIND_READ_OVR, 0, 24'h000000, 1'b0);
        push_word(pkm_pkg::KIND_SAMPLE, 2, 24'd50, 1'b0);          // below floor
        push_word(pkm_pkg::KIND_SAMPLE, 3, 24'd84, 1'b0);          // equal to floor
        push_word(pkm_pkg::KIND_SAMPLE, 5, SAMPLE_MOST_NEG, 1'b0); // saturates
        push_word(pkm_pkg::KIND_SAMPLE, 6, {1'b0, pkm_pkg::PEAK_MAX}, 1'b1);
        push_word(pkm_pkg::KIND_SAMPLE, 1, 24'hFFFFFF, 1'b0);
        push_word(pkm_pkg::KIND_SAMPLE, 7, -24'sd100, 1'b0);
        push_word(pkm_pkg::KIND_READ_CH, 5, 24'h000000, 1'b1);
        push_word(pkm_pkg::KIND_READ_CH, 5, 24'hFFFFFF, 1'b0);
        push_word(pkm_pkg::KIND_READ_OVR, 4, 24'h000000, 1'b1);
        push_word(pkm_pkg::KIND_READ_OVR, 4, 24'h000000, 1'b0);
        push_word(pkm_pkg::KIND_READ_ALL, 0, 24'h000000, 1'b1);
        push_word(pkm_pkg::KIND_READ_ALL, 0, 24'h000000, 1'b0);
        push_word(pkm_pkg::KIND_CLEAR, 0, 24'h000000, 1'b0);
        push_word(pkm_pkg::KIND_READ_CH, 0, 24'h000000, 1'b0);
        push_word(pkm_pkg::KIND_BITS'(KIND_SPARE + 2), 7, 24'h7FFFFF, 1'b1);

        // Fewer active channels: out-of-range samples dropped, reads flagged
        set_channels(4'd3);
        push_word(pkm_pkg::KIND_SAMPLE, 5, 24'h123456, 1'b0);
        push_word(pkm_pkg::KIND_READ_CH, 6, 24'h000000, 1'b1);
        push_word(pkm_pkg::KIND_SAMPLE, 2, 24'h400000, 1'b0);
        push_word(pkm_pkg::KIND_READ_ALL, 0, 24'h000000, 1'b0);

        // No active channel at all
        set_channels(4'd0);
        push_word(pkm_pkg::KIND_READ_ALL, 0, 24'h000000, 1'b1);
        push_word(pkm_pkg::KIND_READ_CH, 0, 24'h000000, 1'b1);
        push_word(pkm_pkg::KIND_READ_OVR, 0, 24'h000000, 1'b0);
        push_word(pkm_pkg::KIND_SAMPLE, 0, 24'h7FFFFF, 1'b0);

        set_channels(4'd15);
        run_mix(42);
        set_channels(4'd1);
        run_mix(42);
        set_channels(4'd8);
        run_mix(42);
        set_channels(4'd5);
        run_mix(42);
        set_channels(4'd2);
        run_mix(42);
        repeat (2)
        begin
            set_channels(pkm_pkg::CNT_BITS'($urandom_range(1, 8)));
            run_mix(42);
        end

        drain();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pkm_pkg.sv
rtl/pkm_mag_cmp.sv
rtl/pkm_seq.sv
rtl/multichannel_peak_meter.sv
rtl/pkm_checker.sv
tb/sv/multichannel_peak_meter_test.sv
